// ----- hw/rtl/sui_pkg.sv -----
// Package: shared constants, types and state encoding for the sorted unique set.
`default_nettype none
package sui_pkg;

  localparam int unsigned SetDepthDefault = 16;
  localparam int unsigned ValueWidth      = 32;
  localparam int unsigned CountOutWidth   = 5;

  localparam logic OpInsert = 1'b0;
  localparam logic OpProbe  = 1'b1;

  typedef enum logic [1:0] {
    StIdle,
    StCmp,
    StScan,
    StDone
  } sui_state_e;

  // Broadcast controls from the sequencer to every cell.
  typedef struct packed {
    logic cmp_en;
    logic scan_en;
    logic shift_en;
  } cell_ctrl_t;

  // Data handed from one cell to its right-hand neighbor.
  typedef struct packed {
    logic signed [ValueWidth-1:0] elem;
    logic                         occ;
    logic                         lt;
    logic                         found;
  } cell_link_t;

endpackage
`default_nettype wire

// ----- hw/rtl/sui_cell.sv -----
// One storage cell of the sorted set chain: compare, found ripple and shift-insert.
`default_nettype none
module sui_cell (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  sui_pkg::cell_ctrl_t                    ctrl_i,
  input  logic signed [sui_pkg::ValueWidth-1:0]  value_i,
  input  sui_pkg::cell_link_t                    prev_i,
  output sui_pkg::cell_link_t                    link_o
);

  logic signed [sui_pkg::ValueWidth-1:0] elem_q;
  logic                                  occ_q;
  logic                                  lt_q;
  logic                                  eq_q;
  logic                                  found_q;

  // shift-insert happens only in cells at or past the insertion point
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q   <= 1'b0;
      lt_q    <= 1'b0;
      eq_q    <= 1'b0;
      found_q <= 1'b0;
    end else begin
      if (ctrl_i.cmp_en) begin
        lt_q    <= occ_q && (elem_q < value_i);
        eq_q    <= occ_q && (elem_q == value_i);
        found_q <= 1'b0;
      end else if (ctrl_i.scan_en) begin
        found_q <= prev_i.found | eq_q;
      end
      if (ctrl_i.shift_en && !lt_q) begin
        occ_q <= prev_i.lt ? 1'b1 : prev_i.occ;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift_en && !lt_q) begin
      elem_q <= prev_i.lt ? value_i : prev_i.elem;
    end
  end

  assign link_o.elem  = elem_q;
  assign link_o.occ   = occ_q;
  assign link_o.lt    = lt_q;
  assign link_o.found = found_q;

endmodule
`default_nettype wire

// ----- hw/rtl/sorted_unique_set_insert_intersect.sv -----
// Sorted unique set: a chain of SET_DEPTH cells holds distinct signed 32-bit values in
// ascending order. An insert word (operation 0) places its value in sorted position unless
// it is already held; a new value offered to a full set is flagged rejected_full. A probe
// word (operation 1) only reports membership, so a streamed ascending set yields its
// ordered intersection on was_present. Every input word gives one output word. One word is
// worked on at a time: after accept, every cell compares against the value in StCmp, the
// found flag ripples down the chain one cell per cycle in StScan, and in StDone the cells
// shift-insert and the output register is loaded, both held off while a finished word
// waits there under out_stall_i. A finished word may wait in the output register while
// the next input word is accepted. The set is empty after reset.
`default_nettype none
module sorted_unique_set_insert_intersect #(
  parameter int unsigned SET_DEPTH = sui_pkg::SetDepthDefault
) (
  input  logic                                       clk_i,
  input  logic                                       rst_ni,
  input  logic                                       in_valid_i,
  output logic                                       in_stall_o,
  input  logic                                       operation_i,
  input  logic signed [sui_pkg::ValueWidth-1:0]      value_i,
  output logic                                       out_valid_o,
  input  logic                                       out_stall_i,
  output logic signed [sui_pkg::ValueWidth-1:0]      value_echo_o,
  output logic                                       was_present_o,
  output logic                                       added_o,
  output logic                                       rejected_full_o,
  output logic [sui_pkg::CountOutWidth-1:0]          element_count_o
);

  localparam int unsigned CntW  = $clog2(SET_DEPTH + 1);
  localparam int unsigned ScanW = $clog2(SET_DEPTH);

  sui_pkg::sui_state_e                   state_q, state_d;
  logic [ScanW-1:0]                      scan_q;
  logic [CntW-1:0]                       count_q;
  logic [CntW-1:0]                       count_next;
  logic [CntW+sui_pkg::CountOutWidth-1:0] count_ext;
  logic                                  op_q;
  logic signed [sui_pkg::ValueWidth-1:0] value_q;
  logic                                  out_vld_q;
  logic signed [sui_pkg::ValueWidth-1:0] echo_q;
  logic                                  present_q;
  logic                                  added_q;
  logic                                  rejected_q;
  logic [sui_pkg::CountOutWidth-1:0]     ecount_q;

  sui_pkg::cell_ctrl_t ctrl;
  sui_pkg::cell_link_t link [SET_DEPTH+1];

  logic in_accept;
  logic out_load;
  logic present;
  logic full;
  logic insert_new;
  logic do_add;

  assign in_accept  = in_valid_i && !in_stall_o;
  assign present    = link[SET_DEPTH].found;
  assign full       = (count_q == CntW'(SET_DEPTH));
  assign insert_new = (op_q == sui_pkg::OpInsert) && !present;
  assign do_add     = insert_new && !full;
  assign count_next = do_add ? count_q + 1'b1 : count_q;
  assign count_ext  = (CntW + sui_pkg::CountOutWidth)'(count_next);

  // head of chain: nothing stored, insertion point if cell 0 is not below value
  assign link[0].elem  = '0;
  assign link[0].occ   = 1'b0;
  assign link[0].lt    = 1'b1;
  assign link[0].found = 1'b0;

  for (genvar i = 0; i < SET_DEPTH; i++) begin : g_cell
    sui_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .value_i (value_q),
      .prev_i  (link[i]),
      .link_o  (link[i+1])
    );
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      sui_pkg::StIdle: begin
        if (in_valid_i) state_d = sui_pkg::StCmp;
      end
      sui_pkg::StCmp: begin
        state_d = sui_pkg::StScan;
      end
      sui_pkg::StScan: begin
        if (scan_q == '0) state_d = sui_pkg::StDone;
      end
      sui_pkg::StDone: begin
        if (out_load) state_d = sui_pkg::StIdle;
      end
      default: begin
        state_d = sui_pkg::StIdle;
      end
    endcase
  end

  always_comb begin
    in_stall_o    = 1'b1;
    ctrl.cmp_en   = 1'b0;
    ctrl.scan_en  = 1'b0;
    out_load      = 1'b0;
    case (state_q)
      sui_pkg::StIdle: begin
        in_stall_o = 1'b0;
      end
      sui_pkg::StCmp: begin
        ctrl.cmp_en = 1'b1;
      end
      sui_pkg::StScan: begin
        ctrl.scan_en = 1'b1;
      end
      sui_pkg::StDone: begin
        out_load = !out_vld_q || !out_stall_i;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
    ctrl.shift_en = out_load && do_add;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= sui_pkg::StIdle;
      scan_q    <= '0;
      count_q   <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (ctrl.cmp_en) begin
        scan_q <= ScanW'(SET_DEPTH - 1);
      end else if (ctrl.scan_en) begin
        scan_q <= scan_q - 1'b1;
      end
      if (ctrl.shift_en) begin
        count_q <= count_next;
      end
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q    <= operation_i;
      value_q <= value_i;
    end
    if (out_load) begin
      echo_q     <= value_q;
      present_q  <= present;
      added_q    <= do_add;
      rejected_q <= insert_new && full;
      ecount_q   <= count_ext[sui_pkg::CountOutWidth-1:0];
    end
  end

  assign out_valid_o     = out_vld_q;
  assign value_echo_o    = echo_q;
  assign was_present_o   = present_q;
  assign added_o         = added_q;
  assign rejected_full_o = rejected_q;
  assign element_count_o = ecount_q;

endmodule
`default_nettype wire

// ----- hw/rtl/sui_checker.sv -----
// Checker: port-level assertions for the sorted unique set, bound to the top level.
`default_nettype none
module sui_checker (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  input  logic                                  in_stall_o,
  input  logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  input  logic signed [sui_pkg::ValueWidth-1:0] value_echo_o,
  input  logic                                  was_present_o,
  input  logic                                  added_o,
  input  logic                                  rejected_full_o
);

  a_add_xor_reject: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(added_o && rejected_full_o))
    else $error("added and rejected_full both set");

  a_add_not_present: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(added_o && was_present_o))
    else $error("added a value that was already present");

  a_reject_not_present: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(rejected_full_o && was_present_o))
    else $error("rejected a value that was already present");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("second word accepted while one is in work");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(value_echo_o)))
    else $error("stalled output word changed");

endmodule

bind sorted_unique_set_insert_intersect sui_checker u_sui_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .value_echo_o    (value_echo_o),
  .was_present_o   (was_present_o),
  .added_o         (added_o),
  .rejected_full_o (rejected_full_o)
);
`default_nettype wire

// ----- verif/sorted_unique_set_insert_intersect_tb.sv -----
// Testbench for the sorted unique set: directed and random insert/probe words, scoreboard check.
`timescale 1ns / 100ps
module sorted_unique_set_insert_intersect_tb;

  localparam int unsigned SetDepth   = sui_pkg::SetDepthDefault;
  localparam int unsigned CycleLimit = 400_000;
  localparam logic signed [sui_pkg::ValueWidth-1:0] ValMin = 32'sh8000_0000;
  localparam logic signed [sui_pkg::ValueWidth-1:0] ValMax = 32'sh7fff_ffff;

  typedef struct packed {
    logic signed [sui_pkg::ValueWidth-1:0] value_echo;
    logic                                  was_present;
    logic                                  added;
    logic                                  rejected_full;
    logic [sui_pkg::CountOutWidth-1:0]     element_count;
  } set_result_t;

  logic                                    clk_i = 1'b0;
  logic                                    rst_ni;
  logic                                    in_valid_i;
  logic                                    in_stall_o;
  logic                                    operation_i;
  logic signed [sui_pkg::ValueWidth-1:0]   value_i;
  logic                                    out_valid_o;
  logic                                    out_stall_i;
  logic signed [sui_pkg::ValueWidth-1:0]   value_echo_o;
  logic                                    was_present_o;
  logic                                    added_o;
  logic                                    rejected_full_o;
  logic [sui_pkg::CountOutWidth-1:0]       element_count_o;

  logic signed [sui_pkg::ValueWidth-1:0] set_vals [SetDepth];
  int unsigned                  set_count;
  set_result_t                  pending_results [$];
  int unsigned                  words_sent;
  int unsigned                  err_count;
  int unsigned                  cycle_count;
  bit                           idle_on;
  int unsigned                  holdoff_req;
  int unsigned                  holdoff_left;
  int unsigned                  stall_burst_left;

  sorted_unique_set_insert_intersect #(
    .SET_DEPTH(SetDepth)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .operation_i    (operation_i),
    .value_i        (value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .value_echo_o   (value_echo_o),
    .was_present_o  (was_present_o),
    .added_o        (added_o),
    .rejected_full_o(rejected_full_o),
    .element_count_o(element_count_o)
  );

  always #5ns clk_i = ~clk_i;

  // Set model: membership test, sorted insertion, full-set rejection.
  function automatic set_result_t apply_set_word(input logic op,
                                                 input logic signed [sui_pkg::ValueWidth-1:0] v);
    int          pos;
    int          k;
    bit          present;
    set_result_t r;
    pos = 0;
    while (pos < int'(set_count) && set_vals[pos] < v) pos++;
    present = (pos < int'(set_count)) && (set_vals[pos] == v);
    r.value_echo    = v;
    r.was_present   = present;
    r.added         = 1'b0;
    r.rejected_full = 1'b0;
    if (op == sui_pkg::OpInsert && !present) begin
      if (set_count >= SetDepth) begin
        r.rejected_full = 1'b1;
      end else begin
        for (k = int'(set_count); k > pos; k--) set_vals[k] = set_vals[k-1];
        set_vals[pos] = v;
        set_count++;
        r.added = 1'b1;
      end
    end
    r.element_count = set_count[sui_pkg::CountOutWidth-1:0];
    return r;
  endfunction

  function automatic bit set_holds(input logic signed [sui_pkg::ValueWidth-1:0] v);
    for (int i = 0; i < int'(set_count); i++) if (set_vals[i] == v) return 1'b1;
    return 1'b0;
  endfunction

  function automatic logic signed [sui_pkg::ValueWidth-1:0] pick_member();
    if (set_count == 0) return $urandom;
    return set_vals[$urandom_range(0, set_count - 1)];
  endfunction

  function automatic logic signed [sui_pkg::ValueWidth-1:0] pick_nearby_or_random();
    case ($urandom_range(0, 4))
      0: return pick_member() + 1;
      1: return pick_member() - 1;
      2: return $urandom_range(0, 1) ? ValMax : ValMin;
      3: return $signed(32'($urandom_range(0, 64))) - 32;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_word(input logic op, input logic signed [sui_pkg::ValueWidth-1:0] val);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    operation_i <= op;
    value_i     <= val;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_results.push_back(apply_set_word(op, val));
    words_sent++;
  endtask

  task automatic wait_results_drained();
    if (pending_results.size() != 0) begin
      in_valid_i <= 1'b0;
      while (pending_results.size() != 0) @(posedge clk_i);
    end
  endtask

  task automatic test_empty_set();
    send_word(sui_pkg::OpProbe, ValMin);
    send_word(sui_pkg::OpProbe, 32'sd0);
    send_word(sui_pkg::OpProbe, ValMax);
  endtask

  task automatic test_insert_order();
    send_word(sui_pkg::OpInsert, 32'sd0);
    send_word(sui_pkg::OpInsert, ValMax);
    send_word(sui_pkg::OpInsert, ValMin);
    send_word(sui_pkg::OpInsert, -32'sd1);
    send_word(sui_pkg::OpInsert, 32'sd1);
    send_word(sui_pkg::OpInsert, 32'sd100);
    send_word(sui_pkg::OpInsert, -32'sd100);
  endtask

  task automatic test_duplicates();
    send_word(sui_pkg::OpInsert, 32'sd0);
    send_word(sui_pkg::OpInsert, ValMin);
    send_word(sui_pkg::OpInsert, ValMax);
  endtask

  task automatic test_probe_stream();
    send_word(sui_pkg::OpProbe, ValMin);
    send_word(sui_pkg::OpProbe, -32'sd100);
    send_word(sui_pkg::OpProbe, -32'sd2);
    send_word(sui_pkg::OpProbe, -32'sd1);
    send_word(sui_pkg::OpProbe, 32'sd0);
    send_word(sui_pkg::OpProbe, 32'sd2);
    send_word(sui_pkg::OpProbe, 32'sd100);
    send_word(sui_pkg::OpProbe, ValMax);
    // out of order
    send_word(sui_pkg::OpProbe, 32'sd1);
    send_word(sui_pkg::OpProbe, -32'sd1);
  endtask

  task automatic test_random_mix(input int unsigned n_words);
    int unsigned target;
    int unsigned sel;
    int unsigned len;
    int          stream [$];
    target = words_sent + n_words;
    while (words_sent < target) begin
      sel = $urandom_range(0, 99);
      if (sel < 45) begin
        stream.delete();
        len = $urandom_range(3, 12);
        repeat (len) begin
          stream.push_back($urandom_range(0, 9) < 6 ? pick_member() : pick_nearby_or_random());
        end
        stream.sort();
        foreach (stream[i]) send_word(sui_pkg::OpProbe, stream[i]);
      end else if (sel < 80) begin
        repeat ($urandom_range(1, 6)) begin
          send_word(sui_pkg::OpInsert,
                    $urandom_range(0, 99) < 85 ? pick_member() : pick_nearby_or_random());
        end
      end else if (sel < 97) begin
        send_word(logic'($urandom_range(0, 1)), $urandom);
      end else begin
        wait_results_drained();
      end
    end
  endtask

  task automatic test_full_set();
    logic signed [sui_pkg::ValueWidth-1:0] v;
    while (set_count < SetDepth) send_word(sui_pkg::OpInsert, $urandom);
    wait_results_drained();
    do v = $urandom; while (set_holds(v));
    send_word(sui_pkg::OpInsert, v);
    send_word(sui_pkg::OpInsert, pick_member());
    send_word(sui_pkg::OpProbe, v);
    send_word(sui_pkg::OpProbe, pick_member());
  endtask

  task automatic test_receiver_holdoff();
    holdoff_req = 400;
    repeat (8) begin
      send_word(logic'($urandom_range(0, 1)), pick_member());
    end
  endtask

  task automatic test_no_idle();
    idle_on = 1'b0;
    test_random_mix(80);
  endtask

  always @(posedge clk_i) begin
    if (holdoff_req != 0) begin
      holdoff_left = holdoff_req;
      holdoff_req  = 0;
    end
    if (holdoff_left != 0) begin
      out_stall_i <= 1'b1;
      holdoff_left--;
    end else if (stall_burst_left != 0) begin
      out_stall_i <= 1'b1;
      stall_burst_left--;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      out_stall_i <= 1'b1;
      stall_burst_left = $urandom_range(0, 17);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin : check_results
    set_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result word, value_echo %0d", value_echo_o);
        err_count++;
      end else begin
        want = pending_results.pop_front();
        if (value_echo_o !== want.value_echo) begin
          $error("value_echo: expected %0d, got %0d", want.value_echo, value_echo_o);
          err_count++;
        end
        if (was_present_o !== want.was_present) begin
          $error("was_present: expected %0b, got %0b", want.was_present, was_present_o);
          err_count++;
        end
        if (added_o !== want.added) begin
          $error("added: expected %0b, got %0b", want.added, added_o);
          err_count++;
        end
        if (rejected_full_o !== want.rejected_full) begin
          $error("rejected_full: expected %0b, got %0b", want.rejected_full, rejected_full_o);
          err_count++;
        end
        if (element_count_o !== want.element_count) begin
          $error("element_count: expected %0d, got %0d", want.element_count, element_count_o);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    rst_ni           = 1'b0;
    in_valid_i       = 1'b0;
    operation_i      = sui_pkg::OpInsert;
    value_i          = '0;
    out_stall_i      = 1'b0;
    set_count        = 0;
    words_sent       = 0;
    err_count        = 0;
    cycle_count      = 0;
    idle_on          = 1'b1;
    holdoff_req      = 0;
    holdoff_left     = 0;
    stall_burst_left = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_set();
    test_insert_order();
    test_duplicates();
    test_probe_stream();
    test_random_mix(300);
    test_full_set();
    test_receiver_holdoff();
    test_random_mix(300);
    test_no_idle();

    wait_results_drained();
    repeat (SetDepth + 8) @(posedge clk_i);
    if (err_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
